FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/ntsa_pkg.sv
// Types and constants of the neighbor table with sequence aging.
`timescale 1ns / 1ps

package ntsa_pkg;

  localparam int NEIGHBORS   = 8;
  localparam int IDX_W       = $clog2(NEIGHBORS);
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = 3;
  localparam int SEQ_W       = 16;
  localparam int ADDR_W      = 32;

  localparam logic [SEQ_W-1:0] WINDOW_RESET = 16'd1024;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_ADVANCE  = 2'd1;
  localparam logic [1:0] CMD_LIST     = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [SEQ_W-1:0]  reply_seq;
    logic [ADDR_W-1:0] node_addr;
  } request_t;

  typedef struct packed {
    logic              has_data;
    logic [ADDR_W-1:0] neighbor_addr;
    logic [SLOT_W-1:0] slot;
    logic              shifted;
    logic [SEQ_W-1:0]  seq_value;
    logic              last;
  } result_t;

endpackage

FILE: rtl/neighbor_table_seq_aging.sv
// Neighbor table with sequence-number aging: top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Eight-slot neighbor table keyed by address, aged by a 16-bit sequence count.
// Input channel: request is transferred at a rising edge with start high and
// busy low. Commands: register neighbor, advance sequence, list live ones;
// the unused code is dropped with no result.
// Output channel: each result sits on result for exactly one cycle with
// result_valid high; the receiver cannot stall, so none is held back.
// result.last marks the final result of a command.
// Config: window_we/window_data write window at any edge (only while
// idle by contract). An entry is expired once its age reaches the window.
// Per command; register and list share one 16-bit subtractor, one slot a cycle:
//   advance  - result in the cycle after the transfer, busy never rises.
//   register - a reply-age step, then the slot scan from slot 0 until a hit;
//              with no hit the table shifts one slot a cycle from the top
//              down, and the new entry lands in slot 0.
//   list     - the slot scan, then a close step; results come out one slot
//              late so that the final one carries last.
// Reset clears the valid bits, the sequence count and the strobe, and loads
// the window with 1024; entry payload is not reset.
module neighbor_table_seq_aging
  import ntsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  request_t         request,
  output logic             result_valid,
  output result_t          result,
  input  logic             window_we,
  input  logic [SEQ_W-1:0] window_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REG_AGE,
    S_REG_SCAN,
    S_SHIFT,
    S_LIST_SCAN,
    S_LIST_END
  } state_t;

  state_t state;

  // table storage; valid bits reset, payload only meaningful when valid
  logic [NEIGHBORS-1:0] valid;
  logic [SEQ_W-1:0]     entry_seq  [NEIGHBORS];
  logic [ADDR_W-1:0]    entry_addr [NEIGHBORS];

  logic [SEQ_W-1:0]     cur_seq;
  logic [SEQ_W-1:0]     window;
  request_t             req_q;
  logic [SEQ_W-1:0]     reply_age;
  logic [IDX_W-1:0]     idx;

  // one-deep hold for list results, so last can be set on the final one
  logic                 pend_valid;
  logic [ADDR_W-1:0]    pend_addr;
  logic [IDX_W-1:0]     pend_slot;
  logic [CNT_W-1:0]     cnt;

  // single read port and the shared subtractor
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_valid;
  logic [SEQ_W-1:0]     rd_seq;
  logic [ADDR_W-1:0]    rd_addr;
  logic [SEQ_W-1:0]     sub_b;
  logic [SEQ_W-1:0]     diff;
  logic                 is_expired;
  logic                 is_live;
  logic                 reg_hit;
  logic                 idx_at_end;

  // single write port
  logic                 wr_en;
  logic                 wr_vbit;
  logic [IDX_W-1:0]     wr_idx;
  logic [SEQ_W-1:0]     wr_seq;
  logic [ADDR_W-1:0]    wr_addr;

  assign busy = (state != S_IDLE);

  // shifting copies slot idx-1 into slot idx
  assign rd_idx   = (state == S_SHIFT) ? (idx - 1'b1) : idx;
  assign rd_valid = valid[rd_idx];
  assign rd_seq   = entry_seq[rd_idx];
  assign rd_addr  = entry_addr[rd_idx];

  // age = current - seq, mod 2^16; first pass ages the reply itself
  assign sub_b      = (state == S_REG_AGE) ? req_q.reply_seq : rd_seq;
  assign diff       = cur_seq - sub_b;
  assign is_expired = (diff >= window);
  assign is_live    = rd_valid && !is_expired;
  assign reg_hit    = !rd_valid || is_expired ||
                      ((rd_addr == req_q.node_addr) && (diff > reply_age));
  assign idx_at_end = (idx == IDX_W'(NEIGHBORS - 1));

  always_comb begin
    wr_en   = 1'b0;
    wr_vbit = 1'b1;
    wr_idx  = idx;
    wr_seq  = req_q.reply_seq;
    wr_addr = req_q.node_addr;
    unique case (state)
      S_REG_SCAN: begin
        wr_en = reg_hit;
      end
      S_SHIFT: begin
        wr_en = 1'b1;
        if (idx != '0) begin
          wr_vbit = rd_valid;
          wr_seq  = rd_seq;
          wr_addr = rd_addr;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_seq[wr_idx]  <= wr_seq;
      entry_addr[wr_idx] <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      cur_seq      <= '0;
      window       <= WINDOW_RESET;
      result_valid <= 1'b0;
      result       <= '0;
      idx          <= '0;
      pend_valid   <= 1'b0;
      cnt          <= '0;
    end else begin
      result_valid <= 1'b0;
      if (window_we) begin
        window <= window_data;
      end
      if (wr_en) begin
        valid[wr_idx] <= wr_vbit;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q      <= request;
            idx        <= '0;
            pend_valid <= 1'b0;
            cnt        <= '0;
            case (request.command)
              CMD_REGISTER: begin
                state <= S_REG_AGE;
              end
              CMD_ADVANCE: begin
                result       <= '{has_data: 1'b1, seq_value: cur_seq, last: 1'b1,
                                  default: '0};
                result_valid <= 1'b1;
                cur_seq      <= cur_seq + 1'b1;
              end
              CMD_LIST: begin
                state <= S_LIST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_REG_AGE: begin
          reply_age <= diff;
          state     <= S_REG_SCAN;
        end
        S_REG_SCAN: begin
          if (reg_hit) begin
            result       <= '{has_data: 1'b1, slot: SLOT_W'(idx), last: 1'b1,
                              default: '0};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (idx_at_end) begin
            state <= S_SHIFT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT: begin
          if (idx != '0) begin
            idx <= idx - 1'b1;
          end else begin
            result       <= '{has_data: 1'b1, shifted: 1'b1, last: 1'b1,
                              default: '0};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_LIST_SCAN: begin
          if (is_live) begin
            if (pend_valid) begin
              result       <= '{has_data: 1'b1, neighbor_addr: pend_addr,
                                slot: SLOT_W'(pend_slot), default: '0};
              result_valid <= 1'b1;
            end
            pend_valid <= 1'b1;
            pend_addr  <= rd_addr;
            pend_slot  <= idx;
            cnt        <= cnt + 1'b1;
          end
          if (idx_at_end || (is_live && (cnt == CNT_W'(MAX_RESULTS - 1)))) begin
            state <= S_LIST_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_LIST_END: begin
          if (pend_valid) begin
            result <= '{has_data: 1'b1, neighbor_addr: pend_addr,
                        slot: SLOT_W'(pend_slot), last: 1'b1, default: '0};
          end else begin
            result <= '{last: 1'b1, default: '0};
          end
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // advance answers in the next cycle with the count from before the step
  `ASSERT_NEXT(a_advance_result, clk, rst,
    start && !busy && (request.command == CMD_ADVANCE),
    result_valid && result.last && (result.seq_value == $past(cur_seq)),
    "advance did not return the pre-increment sequence")
  // a shifted table is always written at slot 0
  `ASSERT_IMPLY(a_shift_slot0, clk, rst,
    result_valid && result.shifted,
    result.slot == '0,
    "shifted register result not on slot 0")
  // a non-final result means the command is still running
  `ASSERT_IMPLY(a_more_follows, clk, rst,
    result_valid && !result.last,
    busy,
    "non-final result with the block idle")
  // the unused command code is dropped silently
  `ASSERT_NEXT(a_unused_cmd, clk, rst,
    start && !busy && (request.command != CMD_REGISTER) &&
      (request.command != CMD_ADVANCE) && (request.command != CMD_LIST),
    !result_valid && !busy,
    "unused command produced activity")

endmodule

FILE: dv/neighbor_table_seq_aging_tb.sv
// Self-checking testbench for the neighbor table with sequence-number aging.
`timescale 1ns / 1ps

module neighbor_table_seq_aging_tb;
  import ntsa_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 3;
  // No transfer in either direction for this long means the block hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Settle time, set above the longest register command.
  localparam int QUIET_CYCLES   = 24;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 44;
  // Command code that the block drops without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Shadow of the table plus the queue of results still owed by the block.
  class neighbor_scoreboard;
    bit                slot_valid[NEIGHBORS];
    logic [SEQ_W-1:0]  slot_seq[NEIGHBORS];
    logic [ADDR_W-1:0] slot_addr[NEIGHBORS];
    logic [SEQ_W-1:0]  seq_count;
    logic [SEQ_W-1:0]  window;
    result_t           owed_results[$];
    int                errors;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_seq[i]   = '0;
        slot_addr[i]  = '0;
      end
      seq_count = '0;
      window    = WINDOW_RESET;
      errors    = 0;
    endfunction

    // Age wraps at 16 bits, same as the counter.
    function logic [SEQ_W-1:0] age(logic [SEQ_W-1:0] s);
      return seq_count - s;
    endfunction

    function bit stale(logic [SEQ_W-1:0] s);
      return age(s) >= window;
    endfunction

    function bit live(int i);
      return slot_valid[i] && !stale(slot_seq[i]);
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Called once per accepted request; queues what the block must return.
    function void note_request(request_t req);
      result_t res;
      int      hit;
      int      live_cnt;
      int      n;
      res = '0;
      hit = -1;
      case (req.command)
        CMD_REGISTER: begin
          // First slot that is free, aged out, or an older copy of this node.
          for (int i = 0; i < NEIGHBORS; i++) begin
            if (hit < 0 && (!slot_valid[i] || stale(slot_seq[i]) ||
                            (slot_addr[i] == req.node_addr &&
                             age(slot_seq[i]) > age(req.reply_seq))))
              hit = i;
          end
          if (hit < 0) begin
            // Table full of live entries: push everything up, lose the top.
            for (int i = NEIGHBORS - 1; i > 0; i--) begin
              slot_valid[i] = slot_valid[i-1];
              slot_seq[i]   = slot_seq[i-1];
              slot_addr[i]  = slot_addr[i-1];
            end
            hit         = 0;
            res.shifted = 1'b1;
          end
          slot_valid[hit] = 1'b1;
          slot_seq[hit]   = req.reply_seq;
          slot_addr[hit]  = req.node_addr;
          res.has_data    = 1'b1;
          res.slot        = SLOT_W'(hit);
          res.last        = 1'b1;
          owed_results.push_back(res);
        end
        CMD_ADVANCE: begin
          res.has_data  = 1'b1;
          res.seq_value = seq_count;
          res.last      = 1'b1;
          owed_results.push_back(res);
          seq_count++;
        end
        CMD_LIST: begin
          live_cnt = 0;
          for (int i = 0; i < NEIGHBORS; i++)
            if (live(i)) live_cnt++;
          if (live_cnt > MAX_RESULTS) live_cnt = MAX_RESULTS;
          if (live_cnt == 0) begin
            // Nothing live: a single empty result closes the list.
            res.last = 1'b1;
            owed_results.push_back(res);
          end else begin
            n = 0;
            for (int i = 0; i < NEIGHBORS; i++) begin
              if (live(i) && n < live_cnt) begin
                res               = '0;
                res.has_data      = 1'b1;
                res.neighbor_addr = slot_addr[i];
                res.slot          = SLOT_W'(i);
                res.last          = (n == live_cnt - 1);
                owed_results.push_back(res);
                n++;
              end
            end
          end
        end
        default: ; // unused code: no result, table untouched
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = owed_results.pop_front();
      if (got.has_data !== want.has_data)
        report($sformatf("has_data %b, want %b", got.has_data, want.has_data));
      if (got.neighbor_addr !== want.neighbor_addr)
        report($sformatf("neighbor_addr %h, want %h", got.neighbor_addr,
                         want.neighbor_addr));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.shifted !== want.shifted)
        report($sformatf("shifted %b, want %b", got.shifted, want.shifted));
      if (got.seq_value !== want.seq_value)
        report($sformatf("seq_value %h, want %h", got.seq_value, want.seq_value));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  request_t         request;
  logic             result_valid;
  result_t          result;
  logic             window_we;
  logic [SEQ_W-1:0] window_data;

  neighbor_table_seq_aging dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .window_we    (window_we),
    .window_data  (window_data)
  );

  neighbor_scoreboard sb;
  int                 sender_idle_pct;
  int                 quiet_count = 0;
  logic [ADDR_W-1:0]  addr_pool[16];
  logic [SEQ_W-1:0]   phase_window[PHASES];

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Results cannot be held off: every strobe is a transfer.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  // Hang detector: any transfer in either direction restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("neighbor_table_seq_aging: mismatch");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic request_t make_req(logic [1:0] cmd, logic [SEQ_W-1:0] seq,
                                        logic [ADDR_W-1:0] addr);
    request_t r;
    r.command   = cmd;
    r.reply_seq = seq;
    r.node_addr = addr;
    return r;
  endfunction

  // Random idle gap, then hold start until the block takes the transfer.
  // start stays high across back-to-back transfers.
  task automatic send(request_t req);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
  endtask

  // Stop sending and let every owed result come back, then settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Window changes only with the block idle.
  task automatic set_window(logic [SEQ_W-1:0] w);
    drain();
    window_we   <= 1'b1;
    window_data <= w;
    @(posedge clk);
    window_we <= 1'b0;
    sb.window  = w;
  endtask

  // Mostly replies near the current count, so ages straddle the window and
  // same-node refreshes go both ways; the rest anywhere in the 16-bit space.
  task automatic random_item();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      r.command = CMD_REGISTER;
    else if (pick < 78) r.command = CMD_ADVANCE;
    else if (pick < 95) r.command = CMD_LIST;
    else                r.command = CMD_UNUSED;
    if ($urandom_range(0, 9) < 7)
      r.reply_seq = SEQ_W'(sb.seq_count - $urandom_range(0, 48));
    else
      r.reply_seq = SEQ_W'($urandom);
    if ($urandom_range(0, 9) < 8) r.node_addr = addr_pool[$urandom_range(0, 15)];
    else                          r.node_addr = $urandom;
    send(r);
  endtask

  initial begin
    sb              = new();
    rst             = 1'b1;
    start           = 1'b0;
    request         = '0;
    window_we       = 1'b0;
    window_data     = '0;
    sender_idle_pct = 12;
    // Small address pool so the same node comes back often.
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int k = 2; k < 16; k++) addr_pool[k] = $urandom;
    phase_window = '{16'hFFFF, 16'd1, 16'd6, 16'd1024, 16'd0, 16'd20,
                     16'($urandom_range(2, 64)), 16'($urandom_range(1, 65535))};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset window of 1024.
    send(make_req(CMD_LIST, '0, '0));               // empty table: empty list
    send(make_req(CMD_ADVANCE, '0, '0));            // hands out 0
    send(make_req(CMD_UNUSED, '1, '1));             // dropped silently
    send(make_req(CMD_REGISTER, '0, '0));           // lowest seq and address
    send(make_req(CMD_REGISTER, '1, '1));           // highest seq and address
    send(make_req(CMD_REGISTER, sb.seq_count, '0)); // newer reply refreshes slot
    send(make_req(CMD_REGISTER, '0, '0));           // older reply: takes a new slot
    // Fill the rest; the last one finds no room and shifts the table.
    for (int k = 0; k < 6; k++)
      send(make_req(CMD_REGISTER, sb.seq_count, addr_pool[2+k]));
    send(make_req(CMD_LIST, '0, '0));               // full table: eight results
    send(make_req(CMD_ADVANCE, '0, '0));
    set_window('0);                                 // zero window: all expired
    send(make_req(CMD_LIST, '0, '0));
    send(make_req(CMD_REGISTER, sb.seq_count, addr_pool[8]));
    set_window('1);
    send(make_req(CMD_LIST, '0, '0));
    set_window(16'd1);
    send(make_req(CMD_LIST, '0, '0));
    send(make_req(CMD_ADVANCE, '0, '0));
    send(make_req(CMD_REGISTER, sb.seq_count, addr_pool[9]));

    // Random phases: sender idles 12%, then 57%, then runs flat out.
    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = (p < 3) ? 12 : (p < 6) ? 57 : 0;
      set_window(phase_window[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_item();
        // In even phases, hold off mid-phase until the table has answered everything.
        if (i == PHASE_ITEMS / 2 && p % 2 == 0) drain();
      end
    end

    start <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (2 * QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("neighbor_table_seq_aging: match");
    end else begin
      $display("neighbor_table_seq_aging: mismatch");
    end
    $finish;
  end

endmodule

FILE: neighbor_table_seq_aging.f
+incdir+rtl
rtl/ntsa_pkg.sv
rtl/neighbor_table_seq_aging.sv
dv/neighbor_table_seq_aging_tb.sv
